// ----- hw/rtl/lcdtw_pkg.sv -----
`timescale 1ns / 1ps
// Package for the character LCD text writer: payload structs, register indexes,
// command bytes and special character codes. No dependencies.
package lcdtw_pkg;

    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned CfgDataW = 6;
    localparam int unsigned LineCountW = 2;
    localparam int unsigned LineWidthW = 6;
    localparam int unsigned RowW = 2;
    localparam int unsigned ColW = 6;

    localparam logic [LineCountW-1:0] LineCountReset = 2'd2;
    localparam logic [LineWidthW-1:0] LineWidthReset = 6'd16;

    localparam logic [7:0] CmdClear   = 8'h01;
    localparam logic [7:0] CmdSetAddr = 8'h80;

    localparam logic [7:0] ChNul = 8'd0;
    localparam logic [7:0] ChLf  = 8'd10;
    localparam logic [7:0] ChCr  = 8'd13;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_LINE_COUNT = 2'd0,
        CFG_LINE_WIDTH = 2'd1
    } cfg_index_t;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_CHAR  = 1'b1
    } kind_t;

    typedef enum logic {
        RS_CMD  = 1'b0,
        RS_DATA = 1'b1
    } rs_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } out_item_t;

    // Bytes produced by one input item, handed from layout to the nibble stage.
    typedef struct packed {
        logic       has_out;
        logic       two_bytes;
        logic       rs0;
        logic [7:0] byte0;
        logic       rs1;
        logic [7:0] byte1;
    } byte_pair_t;

    // Set-address command for a row, kept to 8 bits.
    function automatic logic [7:0] row_address(input logic [RowW-1:0] row);
        row_address = CmdSetAddr + {row, 6'b0};
    endfunction

endpackage

// ----- hw/rtl/lcdtw_layout.sv -----
`timescale 1ns / 1ps
// Text layout: cursor state (row, column, end of text) and decode of one item
// into up to two bytes. Depends on lcdtw_pkg.
module lcdtw_layout (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  lcdtw_pkg::in_item_t               item,
    input  logic [lcdtw_pkg::LineCountW-1:0]  line_count,
    input  logic [lcdtw_pkg::LineWidthW-1:0]  line_width,
    output lcdtw_pkg::byte_pair_t             bytes
);

    logic [lcdtw_pkg::RowW-1:0] row_reg, row_next;
    logic [lcdtw_pkg::ColW-1:0] col_reg, col_next;
    logic                       done_reg, done_next;

    logic [lcdtw_pkg::RowW:0]   row_inc;
    logic [lcdtw_pkg::ColW:0]   col_inc;
    logic                       row_ok;
    logic                       past_rows;

    always_comb begin
        row_inc   = {1'b0, row_reg} + 3'd1;
        col_inc   = {1'b0, col_reg} + 7'd1;
        row_ok    = row_inc < {1'b0, line_count};
        past_rows = {1'b0, row_reg} >= {1'b0, line_count};

        row_next  = row_reg;
        col_next  = col_reg;
        done_next = done_reg;
        bytes     = '0;

        if (item.kind == lcdtw_pkg::KIND_START) begin
            row_next        = '0;
            col_next        = '0;
            done_next       = 1'b0;
            bytes.has_out   = 1'b1;
            bytes.rs0       = lcdtw_pkg::RS_CMD;
            bytes.byte0     = lcdtw_pkg::CmdClear;
        end else if (!done_reg) begin
            if (item.char_code == lcdtw_pkg::ChNul || past_rows) begin
                done_next = 1'b1;
            end else if (item.char_code == lcdtw_pkg::ChCr) begin
                done_next = done_reg;
            end else if (item.char_code == lcdtw_pkg::ChLf) begin
                if (row_ok) begin
                    row_next      = row_inc[lcdtw_pkg::RowW-1:0];
                    col_next      = '0;
                    bytes.has_out = 1'b1;
                    bytes.rs0     = lcdtw_pkg::RS_CMD;
                    bytes.byte0   = lcdtw_pkg::row_address(row_inc[lcdtw_pkg::RowW-1:0]);
                end else begin
                    done_next = 1'b1;
                end
            end else begin
                bytes.has_out = 1'b1;
                bytes.rs0     = lcdtw_pkg::RS_DATA;
                bytes.byte0   = item.char_code;
                if (col_inc >= {1'b0, line_width}) begin
                    // wrap to the next row, or end the text on the last row
                    if (row_ok) begin
                        row_next        = row_inc[lcdtw_pkg::RowW-1:0];
                        col_next        = '0;
                        bytes.two_bytes = 1'b1;
                        bytes.rs1       = lcdtw_pkg::RS_CMD;
                        bytes.byte1     =
                            lcdtw_pkg::row_address(row_inc[lcdtw_pkg::RowW-1:0]);
                    end else begin
                        done_next = 1'b1;
                    end
                end else begin
                    col_next = col_inc[lcdtw_pkg::ColW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            done_reg <= 1'b0;
        end else if (step) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            done_reg <= done_next;
        end
    end

endmodule

// ----- hw/rtl/lcdtw_nibble_out.sv -----
`timescale 1ns / 1ps
// Result register and nibble serializer: holds one or two bytes and sends them
// high nibble first, one nibble per transfer. Depends on lcdtw_pkg.
module lcdtw_nibble_out (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  lcdtw_pkg::byte_pair_t   bytes,
    output logic                    free,
    output logic                    m_valid,
    input  logic                    m_ready,
    output lcdtw_pkg::out_item_t    m_data
);

    logic                  valid_reg, valid_next;
    logic [1:0]            idx_reg, idx_next;
    lcdtw_pkg::byte_pair_t pair_reg;
    logic                  is_last;
    logic [7:0]            cur_byte;

    always_comb begin
        cur_byte          = idx_reg[1] ? pair_reg.byte1 : pair_reg.byte0;
        is_last           = idx_reg[0] && (idx_reg[1] || !pair_reg.two_bytes);
        m_valid           = valid_reg;
        m_data.reg_select = idx_reg[1] ? pair_reg.rs1 : pair_reg.rs0;
        m_data.nibble     = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        m_data.last       = is_last;
        free              = !valid_reg || (m_ready && is_last);

        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = '0;
        end else if (valid_reg && m_ready) begin
            valid_next = !is_last;
            idx_next   = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pair_reg <= bytes;
        end
    end

endmodule

// ----- hw/rtl/char_lcd_text_layout_nibbles_unit.sv -----
`timescale 1ns / 1ps
// Top level of the character LCD text writer on a 4-bit bus.
// Depends on lcdtw_pkg, lcdtw_layout and lcdtw_nibble_out.
//
// Usage:
//   s_valid/s_ready/s_data carry text items: kind 0 starts a new text (clear
//   command), kind 1 carries one character byte. m_valid/m_ready/m_data carry
//   nibble writes, high nibble first, with reg_select (command or data) and a
//   last flag on the final nibble caused by an item.
//   cfg_wr_en/cfg_addr/cfg_wdata write line_count (index 0) and line_width
//   (index 1); write them only while the block is idle.
// Path: an item is captured in the input register on its transfer and
//   decoded there; the serializer loads its bytes from there when free, and
//   its first nibble then shows on m_data from the serializer's registers.
// Throughput: one nibble per cycle on the result side while m_ready is high.
//   An item that makes bytes holds the serializer for two nibbles (one byte)
//   or four (data plus wrap address); items with no bytes pass at one per cycle.
// Reset (aresetn low, synchronous): cursor at row 0, column 0, text open,
//   line_count 2, line_width 16, both stages empty.
// Stall: when m_ready is low the current nibble holds; the next item waits in
//   the input register and s_ready drops once that register is full.
module char_lcd_text_layout_nibbles_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lcdtw_pkg::in_item_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lcdtw_pkg::out_item_t            m_data,
    input  logic                            cfg_wr_en,
    input  logic [lcdtw_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [lcdtw_pkg::CfgDataW-1:0]  cfg_wdata
);

    logic [lcdtw_pkg::LineCountW-1:0] line_count_reg;
    logic [lcdtw_pkg::LineWidthW-1:0] line_width_reg;

    logic                  in_valid_reg, in_valid_next;
    lcdtw_pkg::in_item_t   in_item_reg;

    lcdtw_pkg::byte_pair_t bytes;
    logic                  out_free;
    logic                  advance;
    logic                  s_xfer;

    // Configuration registers; unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= lcdtw_pkg::LineCountReset;
            line_width_reg <= lcdtw_pkg::LineWidthReset;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lcdtw_pkg::CFG_LINE_COUNT:
                    line_count_reg <= cfg_wdata[lcdtw_pkg::LineCountW-1:0];
                lcdtw_pkg::CFG_LINE_WIDTH:
                    line_width_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Advance the held item when it makes no bytes, or when the serializer
    // can take its bytes this cycle.
    always_comb begin
        advance       = in_valid_reg && (!bytes.has_out || out_free);
        s_ready       = !in_valid_reg || advance;
        s_xfer        = s_valid && s_ready;
        in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= s_data;
        end
    end

    lcdtw_layout u_layout (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .line_count (line_count_reg),
        .line_width (line_width_reg),
        .bytes      (bytes)
    );

    lcdtw_nibble_out u_nibble_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && bytes.has_out),
        .bytes   (bytes),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hw/rtl/lcdtw_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the LCD text writer, bound to the top level.
// Depends on lcdtw_pkg and char_lcd_text_layout_nibbles_unit.
module lcdtw_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  lcdtw_pkg::out_item_t m_data
);

    logic low_half_reg;
    logic hi_rs_reg;
    logic m_xfer;

    assign m_xfer = m_valid && m_ready;

    // Track whether the next nibble is the low half of a byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_half_reg <= 1'b0;
            hi_rs_reg    <= 1'b0;
        end else if (m_xfer) begin
            low_half_reg <= !low_half_reg;
            hi_rs_reg    <= m_data.reg_select;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_last_on_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && m_data.last |-> low_half_reg)
        else $error("last flag on a high nibble");

    a_byte_rs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && low_half_reg |-> m_data.reg_select == hi_rs_reg)
        else $error("register select changed inside a byte");

endmodule

bind char_lcd_text_layout_nibbles_unit lcdtw_checker u_lcdtw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
